// ===== hw/rtl/gf32_rmac_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2^32) region multiply-accumulate: shared package
// Field widths, register codes, reset values and pipeline item types.
// ----------------------------------------------------------------------------
`default_nettype none

package gf32_rmac_pkg;

  localparam int unsigned GfWordW = 32;
  localparam int unsigned GfHalfW = GfWordW / 2;
  localparam int unsigned GfPartW = GfWordW + GfHalfW - 1;
  localparam int unsigned GfProdW = 2 * GfWordW - 1;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GfWordW-1:0] MultiplierRst = 32'h0000_0001;
  localparam logic [GfWordW-1:0] PolyRst       = 32'h0040_0007;
  localparam logic               AccumRst      = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MULTIPLIER = 2'd0,
    CFG_POLY       = 2'd1,
    CFG_ACCUMULATE = 2'd2
  } rmac_cfg_e;

  typedef struct packed {
    logic [GfPartW-1:0] part_lo;
    logic [GfPartW-1:0] part_hi;
    logic [GfWordW-1:0] dest;
    logic               last;
  } rmac_mul_t;

  typedef struct packed {
    logic [GfProdW-1:0] prod;
    logic [GfWordW-1:0] dest;
    logic               last;
  } rmac_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gf32_region_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// GF(2^32) region multiply-accumulate
// Multiplies each source word by a configured field element, reduces by
// the configured polynomial and optionally XORs into the destination word.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                      payload
//   in       input      in_valid_i / in_ready_o        source_word, dest_word, last_in
//   out      output     out_valid_o / out_ready_i      result_word, last_out
//   cfg      input      cfg_we_i                       cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while out_ready_i stays high; the path is a carry-less
// multiply stage, four reduction stages and an output register.
// Every stage holds its own valid bit; a stall at the output fills empty
// stages first and then backs up to in_ready_o.
// Reset clears valid bits and loads multiplier 1, polynomial 0x400007,
// replace mode.
// ----------------------------------------------------------------------------
`default_nettype none

module gf32_region_multiply_accumulate (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [gf32_rmac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [gf32_rmac_pkg::GfWordW-1:0]    cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [gf32_rmac_pkg::GfWordW-1:0]    source_word_i,
  input  wire logic [gf32_rmac_pkg::GfWordW-1:0]    dest_word_i,
  input  wire logic                                 last_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [gf32_rmac_pkg::GfWordW-1:0]         result_word_o,
  output logic                                      last_out_o
);
  import gf32_rmac_pkg::*;

  localparam int unsigned NumRed = 4;

  logic [GfWordW-1:0] multiplier_q;
  logic [GfWordW-1:0] poly_q;
  logic               accum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiplier_q <= MultiplierRst;
      poly_q       <= PolyRst;
      accum_q      <= AccumRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MULTIPLIER: multiplier_q <= cfg_data_i;
        CFG_POLY:       poly_q       <= cfg_data_i;
        CFG_ACCUMULATE: accum_q      <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // Carry-less multiply, split in two half products
  logic      mul_valid_q;
  logic      mul_ready;
  rmac_mul_t mul_q, mul_d;

  always_comb begin
    mul_d.part_lo = '0;
    mul_d.part_hi = '0;
    for (int k = 0; k < int'(GfHalfW); k++) begin
      if (multiplier_q[k]) begin
        mul_d.part_lo = mul_d.part_lo ^
          ({{(GfPartW-GfWordW){1'b0}}, source_word_i} << k);
      end
      if (multiplier_q[k + int'(GfHalfW)]) begin
        mul_d.part_hi = mul_d.part_hi ^
          ({{(GfPartW-GfWordW){1'b0}}, source_word_i} << k);
      end
    end
    mul_d.dest = dest_word_i;
    mul_d.last = last_in_i;
  end

  assign in_ready_o = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mul_q <= mul_d;
    end
  end

  // Combine halves and reduce
  rmac_item_t red_item [NumRed+1];
  logic       red_valid [NumRed+1];
  logic       red_ready [NumRed+1];

  assign red_item[0].prod = {{GfHalfW{1'b0}}, mul_q.part_lo} ^
                            {mul_q.part_hi, {GfHalfW{1'b0}}};
  assign red_item[0].dest = mul_q.dest;
  assign red_item[0].last = mul_q.last;
  assign red_valid[0]     = mul_valid_q;
  assign mul_ready        = red_ready[0];

  gf32_rmac_reduce #(.TOP_BIT(62), .STEPS(8)) u_red0 (
    .clk_i, .rst_ni, .poly_i(poly_q),
    .valid_i(red_valid[0]), .ready_o(red_ready[0]), .item_i(red_item[0]),
    .valid_o(red_valid[1]), .ready_i(red_ready[1]), .item_o(red_item[1])
  );

  gf32_rmac_reduce #(.TOP_BIT(54), .STEPS(8)) u_red1 (
    .clk_i, .rst_ni, .poly_i(poly_q),
    .valid_i(red_valid[1]), .ready_o(red_ready[1]), .item_i(red_item[1]),
    .valid_o(red_valid[2]), .ready_i(red_ready[2]), .item_o(red_item[2])
  );

  gf32_rmac_reduce #(.TOP_BIT(46), .STEPS(8)) u_red2 (
    .clk_i, .rst_ni, .poly_i(poly_q),
    .valid_i(red_valid[2]), .ready_o(red_ready[2]), .item_i(red_item[2]),
    .valid_o(red_valid[3]), .ready_i(red_ready[3]), .item_o(red_item[3])
  );

  gf32_rmac_reduce #(.TOP_BIT(38), .STEPS(7)) u_red3 (
    .clk_i, .rst_ni, .poly_i(poly_q),
    .valid_i(red_valid[3]), .ready_o(red_ready[3]), .item_i(red_item[3]),
    .valid_o(red_valid[4]), .ready_i(red_ready[4]), .item_o(red_item[4])
  );

  // Output register
  logic               out_valid_q;
  logic [GfWordW-1:0] result_q, result_d;
  logic               last_q;

  assign red_ready[NumRed] = !out_valid_q || out_ready_i;
  assign result_d = red_item[NumRed].prod[GfWordW-1:0] ^
                    (accum_q ? red_item[NumRed].dest : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (red_ready[NumRed]) begin
      out_valid_q <= red_valid[NumRed];
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_valid[NumRed] && red_ready[NumRed]) begin
      result_q <= result_d;
      last_q   <= red_item[NumRed].last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_word_o = result_q;
  assign last_out_o    = last_q;

  a_fully_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_valid[NumRed] |-> (red_item[NumRed].prod[GfProdW-1:GfWordW] == '0))
    else $error("product not fully reduced");

  a_backpressure_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> mul_valid_q && red_valid[1] && red_valid[2] &&
                    red_valid[3] && red_valid[NumRed] && out_valid_q && !out_ready_i)
    else $error("input stalled with an empty stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_valid_q && red_valid[1] && red_valid[2] && red_valid[3] &&
    red_valid[NumRed] && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/gf32_rmac_reduce.sv =====
// ----------------------------------------------------------------------------
// GF(2^32) reduction stage
// Clears a band of high product bits by folding in the field polynomial,
// one pipeline register with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module gf32_rmac_reduce #(
  parameter int unsigned TOP_BIT = 62,
  parameter int unsigned STEPS   = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic [gf32_rmac_pkg::GfWordW-1:0]        poly_i,
  input  wire logic                                     valid_i,
  output logic                                          ready_o,
  input  wire gf32_rmac_pkg::rmac_item_t                item_i,
  output logic                                          valid_o,
  input  wire logic                                     ready_i,
  output gf32_rmac_pkg::rmac_item_t                     item_o
);
  import gf32_rmac_pkg::*;

  logic       valid_q, valid_d;
  rmac_item_t item_q, item_d;

  always_comb begin
    item_d = item_i;
    for (int k = 0; k < int'(STEPS); k++) begin
      if (item_d.prod[int'(TOP_BIT) - k]) begin
        item_d.prod[int'(TOP_BIT) - k] = 1'b0;
        item_d.prod[int'(TOP_BIT) - k - 1 -: GfWordW] =
          item_d.prod[int'(TOP_BIT) - k - 1 -: GfWordW] ^ poly_i;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  a_band_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (item_q.prod[TOP_BIT -: STEPS] == '0))
    else $error("reduced band not cleared");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(item_q))
    else $error("stalled stage lost its item");

endmodule

`default_nettype wire
